/* rtl/assert_macros.svh */
// Assertion macros shared by the cos squared series RTL.
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/cst_pkg.sv */
// Shared types and constants for the cos squared series block.
// Used by cst_sequencer, cst_datapath and cos_squared_taylor_series_top.
package cst_pkg;

    // Number format: 28 fraction bits throughout; input signed Q2.28, result signed Q3.28
    localparam int FRAC_BITS   = 28;
    localparam int X_W         = 31;               // input angle
    localparam int AX_W        = 30;               // |x| after clamp, up to 2.0
    localparam int X2_W        = 31;               // x^2, up to 4.0
    localparam int TWOX2_W     = 32;               // 2 x^2, up to 8.0
    localparam int MAG_W       = 31;               // term magnitude, below 5.34
    localparam int P_W         = 34;               // scaled product before division
    localparam int RECIP_SHIFT = 34;               // reciprocal scale 2^34
    localparam int RECIP_W     = 32;               // floor(2^34 / d) for d >= 6
    localparam int DIV_W       = 13;               // k (2k-1), k up to 64
    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 32;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SUM_W       = 34;
    localparam int OUT_W       = 32;
    localparam int TERMS_W     = 6;
    localparam int TOL_W       = 29;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(26844);
    localparam logic [X_W-1:0]   AX_LIMIT  = X_W'(2 << FRAC_BITS);
    localparam logic [MAG_W-1:0] MAG_INIT  = MAG_W'(1 << (FRAC_BITS - 1));
    localparam logic [SUM_W-1:0] SUM_INIT  = SUM_W'(1 << FRAC_BITS);

    localparam int STEP_W = 4;

    // Multiplier operand pairs
    typedef enum logic [1:0] {
        MS_AXAX   = 2'd0,   // |x| * |x|
        MS_MAGX2  = 2'd1,   // mag * 2x^2
        MS_PRECIP = 2'd2,   // P * reciprocal of k(2k-1)
        MS_QD     = 2'd3    // quotient estimate * k(2k-1)
    } t_mul_sel;

    // Register transfer of a step
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_TWOX2 = 3'd2,
        OP_P     = 3'd3,
        OP_Q     = 3'd4,
        OP_FIX   = 3'd5,
        OP_ACC   = 3'd6,
        OP_OUT   = 3'd7
    } t_op;

    // Next-step rule
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,  // fall through
        C_WAIT_IN  = 3'd1,  // hold until an input beat arrives
        C_K1       = 3'd2,  // jump when k is 1
        C_LOOP     = 3'd3,  // jump unless the series stops
        C_WAIT_OUT = 3'd4   // hold until the output register is free, then jump
    } t_cond;

    typedef struct packed {
        t_mul_sel          mul_sel;
        logic              prod_en;
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic k_one;
        logic stop;
        logic out_free;
    } t_status;

endpackage

/* rtl/cst_sequencer.sv */
// Microcode sequencer: step counter, control store and jump logic.
// Depends on cst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cst_sequencer
    import cst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_ctl    o_ctl
);

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SQ    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_TWOX2 = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_P     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_Q     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FIX   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ACC   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DONE  = 4'd8;

    // Control store
    function automatic t_ctl ucode(input logic [STEP_W-1:0] step);
        t_ctl w;
        w = '{mul_sel: MS_AXAX, prod_en: 1'b0, op: OP_NONE, cond: C_NEXT,
              target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.op   = OP_LOAD;
                w.cond = C_WAIT_IN;
            end
            STEP_SQ: begin
                w.mul_sel = MS_AXAX;
                w.prod_en = 1'b1;
            end
            STEP_TWOX2: begin
                w.op = OP_TWOX2;
            end
            STEP_LOOP: begin
                w.mul_sel = MS_MAGX2;
                w.prod_en = 1'b1;
            end
            STEP_P: begin
                w.mul_sel = MS_PRECIP;
                w.prod_en = 1'b1;
                w.op      = OP_P;
                w.cond    = C_K1;
                w.target  = STEP_ACC;
            end
            STEP_Q: begin
                w.mul_sel = MS_QD;
                w.prod_en = 1'b1;
                w.op      = OP_Q;
            end
            STEP_FIX: begin
                w.op = OP_FIX;
            end
            STEP_ACC: begin
                w.op     = OP_ACC;
                w.cond   = C_LOOP;
                w.target = STEP_LOOP;
            end
            STEP_DONE: begin
                w.op     = OP_OUT;
                w.cond   = C_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            default: begin
                w.cond = C_NEXT;
            end
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctl              w_rom;
    logic              w_in_beat;
    logic              w_hold;

    assign w_rom      = ucode(r_step);
    assign o_in_stall = (r_step != STEP_IDLE);
    assign w_in_beat  = i_in_valid && (r_step == STEP_IDLE);

    // Pick the next step
    always_comb begin
        w_hold = 1'b0;
        n_step = r_step + 1'b1;
        case (w_rom.cond)
            C_NEXT: begin
                n_step = r_step + 1'b1;
            end
            C_WAIT_IN: begin
                w_hold = !w_in_beat;
                n_step = w_in_beat ? r_step + 1'b1 : r_step;
            end
            C_K1: begin
                n_step = i_status.k_one ? w_rom.target : r_step + 1'b1;
            end
            C_LOOP: begin
                n_step = i_status.stop ? r_step + 1'b1 : w_rom.target;
            end
            C_WAIT_OUT: begin
                w_hold = !i_status.out_free;
                n_step = i_status.out_free ? w_rom.target : r_step;
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    // Drop the register transfer and the product load while a wait step holds
    always_comb begin
        o_ctl = w_rom;
        if (w_hold) begin
            o_ctl.op      = OP_NONE;
            o_ctl.prod_en = 1'b0;
        end
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    `ASSERT_IMPL(a_step_range, 1'b1, r_step <= STEP_DONE, "step counter out of program")
    `ASSERT_NEXT(a_acc_stop, (r_step == STEP_ACC) && i_status.stop,
                 r_step == STEP_DONE, "series stop did not reach the done step")
    `ASSERT_NEXT(a_acc_loop, (r_step == STEP_ACC) && !i_status.stop,
                 r_step == STEP_LOOP, "series continue did not return to loop")

endmodule

/* rtl/cst_datapath.sv */
// Datapath: shared multiplier, term and sum registers, divisor tables, output register.
// Depends on cst_pkg and assert_macros.svh; driven by cst_sequencer control words.
`include "assert_macros.svh"

module cst_datapath
    import cst_pkg::*;
#(
    parameter int MAX_TERMS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic signed [X_W-1:0]   i_x_value,
    input  logic [TOL_W-1:0]        i_tolerance,
    output t_status                 o_status,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_cos2_value,
    output logic [TERMS_W-1:0]      o_terms_used,
    output logic                    o_limit_reached
);

    localparam int K_W = $clog2(MAX_TERMS + 1);

    // Divisor k(2k-1) and its reciprocal floor(2^34 / d), indexed by k.
    // Entries below k = 2 are unused: the first term needs no division.
    logic [DIV_W-1:0]   w_div   [MAX_TERMS+1];
    logic [RECIP_W-1:0] w_recip [MAX_TERMS+1];

    for (genvar g = 0; g <= MAX_TERMS; g++) begin : g_tab
        if (g < 2) begin : g_lo
            assign w_div[g]   = '0;
            assign w_recip[g] = '0;
        end else begin : g_hi
            localparam longint unsigned DIV = longint'(g) * longint'(2 * g - 1);
            localparam longint unsigned RCP = (64'd1 << RECIP_SHIFT) / DIV;
            assign w_div[g]   = DIV_W'(DIV);
            assign w_recip[g] = RECIP_W'(RCP);
        end
    end

    logic [AX_W-1:0]         r_ax;
    logic [TWOX2_W-1:0]      r_twox2;
    logic [MAG_W-1:0]        r_mag;
    logic [PROD_W-1:0]       r_prod;
    logic [P_W-1:0]          r_p;
    logic [MAG_W-1:0]        r_q;
    logic signed [SUM_W-1:0] r_sum;
    logic [K_W-1:0]          r_k;
    logic                    r_limit;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_cos2;
    logic [TERMS_W-1:0]      r_terms;
    logic                    r_out_limit;

    logic [X_W-1:0]          w_abs;
    logic [X_W-1:0]          w_ax;
    logic [MUL_A_W-1:0]      w_mul_a;
    logic [MUL_B_W-1:0]      w_mul_b;
    logic [P_W-1:0]          w_p;
    logic [MAG_W-1:0]        w_q0;
    logic [DIV_W-1:0]        w_d;
    logic [P_W-1:0]          w_diff;
    logic signed [SUM_W-1:0] w_mag_s;
    logic                    w_stop_tol;
    logic                    w_stop;
    logic                    w_out_free;
    logic signed [OUT_W-1:0] w_sat;

    // Absolute value of the angle, clamped to 2.0
    assign w_abs = i_x_value[X_W-1] ? (X_W'(0) - X_W'(i_x_value)) : X_W'(i_x_value);
    assign w_ax  = (w_abs > AX_LIMIT) ? AX_LIMIT : w_abs;

    // Product slices: P from a mag * 2x^2 product, quotient estimate from P * recip
    assign w_p  = r_prod[FRAC_BITS+P_W-1:FRAC_BITS];
    assign w_q0 = r_prod[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
    assign w_d  = w_div[r_k];

    // Select multiplier operands
    always_comb begin
        case (i_ctl.mul_sel)
            MS_AXAX: begin
                w_mul_a = MUL_A_W'(r_ax);
                w_mul_b = MUL_B_W'(r_ax);
            end
            MS_MAGX2: begin
                w_mul_a = MUL_A_W'(r_mag);
                w_mul_b = r_twox2;
            end
            MS_PRECIP: begin
                w_mul_a = w_p;
                w_mul_b = w_recip[r_k];
            end
            MS_QD: begin
                w_mul_a = MUL_A_W'(w_q0);
                w_mul_b = MUL_B_W'(w_d);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Remainder after the estimate; one step of correction suffices
    assign w_diff = r_p - r_prod[P_W-1:0];

    // Stop tests on the latest term
    assign w_mag_s    = $signed(SUM_W'(r_mag));
    assign w_stop_tol = (r_mag <= MAG_W'(i_tolerance));
    assign w_stop     = w_stop_tol || (r_k == K_W'(MAX_TERMS));
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_status = '{k_one: (r_k == K_W'(1)), stop: w_stop, out_free: w_out_free};

    // Saturate the sum to 32 bits
    always_comb begin
        if (r_sum[SUM_W-1:OUT_W-1] == '0 || r_sum[SUM_W-1:OUT_W-1] == '1) begin
            w_sat = r_sum[OUT_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // Shared multiplier
    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
    end

    // Series registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_W'(1);
        end else begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_ax  <= AX_W'(w_ax);
                    r_k   <= K_W'(1);
                    r_mag <= MAG_INIT;
                    r_sum <= SUM_INIT;
                end
                OP_TWOX2: begin
                    r_twox2 <= {r_prod[FRAC_BITS+X2_W-1:FRAC_BITS], 1'b0};
                end
                OP_P: begin
                    r_p   <= w_p;
                    r_mag <= r_prod[FRAC_BITS+MAG_W-1:FRAC_BITS];
                end
                OP_Q: begin
                    r_q <= w_q0;
                end
                OP_FIX: begin
                    r_mag <= (w_diff >= P_W'(w_d)) ? r_q + 1'b1 : r_q;
                end
                OP_ACC: begin
                    r_sum   <= r_k[0] ? r_sum - w_mag_s : r_sum + w_mag_s;
                    r_limit <= !w_stop_tol;
                    if (!w_stop) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the result until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_OUT) begin
            r_cos2      <= w_sat;
            r_terms     <= TERMS_W'(r_k);
            r_out_limit <= r_limit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cos2_value    = r_cos2;
    assign o_terms_used    = r_terms;
    assign o_limit_reached = r_out_limit;

    `ASSERT_IMPL(a_k_range, 1'b1, (r_k != '0) && (r_k <= K_W'(MAX_TERMS)),
                 "term counter out of range")
    `ASSERT_IMPL(a_fix_one_step, i_ctl.op == OP_FIX, w_diff < {w_d, 1'b0},
                 "reciprocal estimate off by more than one")
    `ASSERT_IMPL(a_out_when_free, i_ctl.op == OP_OUT, w_out_free,
                 "result loaded over an untaken beat")

endmodule

/* rtl/cos_squared_taylor_series_top.sv */
// Top level of the cos squared series block: tolerance register and core wiring.
// Depends on cst_pkg, cst_sequencer and cst_datapath.

// cos^2(x) by its Taylor series in Q3.28. One angle is taken at a time; the
// input stalls from the beat that is accepted until the result is loaded into
// the output register, so a finished result may wait downstream while the next
// angle is already being accepted. Each term after the first needs three
// products on the one 34x32 multiplier (term times 2x^2, times the reciprocal
// of k(2k-1), quotient times k(2k-1)) and a remainder check; the first term
// needs only the product with 2x^2. The tolerance write port is always
// ready; write it only while idle.
module cos_squared_taylor_series_top
    import cst_pkg::*;
#(
    parameter int MAX_TERMS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [TOL_W-1:0]        i_cfg_data,
    // input angle
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [X_W-1:0]   i_x_value,
    // result
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_cos2_value,
    output logic [TERMS_W-1:0]      o_terms_used,
    output logic                    o_limit_reached
);

    logic [TOL_W-1:0] r_tolerance;
    t_ctl             w_ctl;
    t_status          w_status;

    // Tolerance register, written on each config beat
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tolerance <= i_cfg_data;
        end
    end

    cst_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl)
    );

    cst_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_x_value       (i_x_value),
        .i_tolerance     (r_tolerance),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cos2_value    (o_cos2_value),
        .o_terms_used    (o_terms_used),
        .o_limit_reached (o_limit_reached)
    );

endmodule
